// File: rtl/rsd_pkg.sv
// Shared constants, types and codes for the road signal detector.
package rsd_pkg;

    localparam int WINDOW       = 5;
    localparam int VOTES_NEEDED = 5;
    localparam int VOTE_MAX     = (WINDOW > VOTES_NEEDED) ? WINDOW : VOTES_NEEDED;
    localparam int TALLY_W      = $clog2(VOTE_MAX + 1);
    localparam int PTR_W        = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam int COUNT_W      = 4;
    localparam int DIST_W       = 32;
    localparam int HOLD_W       = 16;

    localparam int IN_FIELDS_W  = COUNT_W + DIST_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 4;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_HOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_HOLD = 1'd1;

    localparam logic [HOLD_W-1:0] FAST_HOLD_RST = 16'd2000;
    localparam logic [HOLD_W-1:0] SLOW_HOLD_RST = 16'd4000;

    localparam logic [COUNT_W-1:0] CNT_SINGLE = 4'd1;
    localparam logic [COUNT_W-1:0] CNT_DOUBLE = 4'd2;
    localparam logic [COUNT_W-1:0] CNT_TRIPLE = 4'd3;

    localparam logic CLASS_SINGLE = 1'b0;
    localparam logic CLASS_TRIPLE = 1'b1;

    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_FAST = 2'd1,
        SIG_SLOW = 2'd2
    } t_sig;

    typedef struct packed {
        logic              cls;
        logic [DIST_W-1:0] dist_mm;
    } t_item;

endpackage

// File: rtl/rsd_front.sv
// Front end: sample window ring, vote tally and line class filter.
module rsd_front
    import rsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [COUNT_W-1:0] i_line_count,
    input  logic [DIST_W-1:0]  i_distance_mm,
    input  logic               i_space,
    output logic               o_ready,
    output logic               o_push,
    output t_item              o_item
);

    logic [COUNT_W-1:0] r_window [WINDOW];
    logic [COUNT_W-1:0] n_window [WINDOW];
    logic [PTR_W-1:0]   r_ptr;
    logic [PTR_W-1:0]   n_ptr;
    logic               r_prev_class;
    logic               n_class;
    logic [TALLY_W-1:0] tally1;
    logic [TALLY_W-1:0] tally2;
    logic [TALLY_W-1:0] tally3;
    logic               win1;
    logic               win2;
    logic               win3;

    assign o_ready = i_space;
    assign o_push  = i_valid && i_space;

    always_comb begin
        tally1 = '0;
        tally2 = '0;
        tally3 = '0;
        for (int i = 0; i < WINDOW; i++) begin
            n_window[i] = (PTR_W'(i) == r_ptr) ? i_line_count : r_window[i];
            if (n_window[i] == CNT_SINGLE) tally1 = tally1 + TALLY_W'(1);
            if (n_window[i] == CNT_DOUBLE) tally2 = tally2 + TALLY_W'(1);
            if (n_window[i] == CNT_TRIPLE) tally3 = tally3 + TALLY_W'(1);
        end
        win1 = (tally1 >= TALLY_W'(VOTES_NEEDED));
        win2 = (tally2 >= TALLY_W'(VOTES_NEEDED));
        win3 = (tally3 >= TALLY_W'(VOTES_NEEDED));
        priority if (win3) begin
            n_class = CLASS_TRIPLE;
        end else if (win2) begin
            n_class = r_prev_class;
        end else if (win1) begin
            n_class = CLASS_SINGLE;
        end else begin
            n_class = r_prev_class;
        end
        n_ptr = (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + PTR_W'(1);
    end

    assign o_item.cls     = n_class;
    assign o_item.dist_mm = i_distance_mm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) r_window[i] <= '0;
            r_ptr        <= '0;
            r_prev_class <= CLASS_SINGLE;
        end else if (o_push) begin
            for (int i = 0; i < WINDOW; i++) r_window[i] <= n_window[i];
            r_ptr        <= n_ptr;
            r_prev_class <= n_class;
        end
    end

endmodule

// File: rtl/rsd_queue.sv
// Short queue of classified requests between front and back end.
module rsd_queue
    import rsd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_space,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_space = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            if (do_push && !do_pop)      r_count <= r_count + QCNT_W'(1);
            else if (do_pop && !do_push) r_count <= r_count - QCNT_W'(1);
        end
    end

endmodule

// File: rtl/rsd_back.sv
// Back end: signal state machine, hold registers and output register.
module rsd_back
    import rsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_item                 i_item,
    output logic                  o_pop,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [HOLD_W-1:0]     i_cfg_wdata,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data
);

    t_sig              r_sig;
    t_sig              n_sig;
    logic [DIST_W-1:0] r_change_dist;
    logic [DIST_W-1:0] diff;
    logic [HOLD_W-1:0] r_fast_hold;
    logic [HOLD_W-1:0] r_slow_hold;
    logic              r_valid;
    logic [1:0]        r_out_sig;
    logic              r_out_cls;
    logic              r_out_chg;
    logic              changed;

    assign o_pop = i_valid && (!r_valid || i_ready);
    assign diff  = i_item.dist_mm - r_change_dist;

    always_comb begin
        n_sig = r_sig;
        if (i_item.cls == CLASS_TRIPLE) begin
            unique case (r_sig)
                SIG_FAST: if (diff > {{(DIST_W-HOLD_W){1'b0}}, r_fast_hold}) n_sig = SIG_SLOW;
                SIG_SLOW: if (diff > {{(DIST_W-HOLD_W){1'b0}}, r_slow_hold}) n_sig = SIG_FAST;
                default:  n_sig = SIG_FAST;
            endcase
        end
    end

    assign changed = (n_sig != r_sig);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_hold <= FAST_HOLD_RST;
            r_slow_hold <= SLOW_HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FAST_HOLD: r_fast_hold <= i_cfg_wdata;
                CFG_SLOW_HOLD: r_slow_hold <= i_cfg_wdata;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig         <= SIG_NONE;
            r_change_dist <= '0;
            r_valid       <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                if (changed) begin
                    r_sig         <= n_sig;
                    r_change_dist <= i_item.dist_mm;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_sig <= n_sig;
            r_out_cls <= i_item.cls;
            r_out_chg <= changed;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, r_out_chg, r_out_cls, r_out_sig};

endmodule

// File: rtl/road_signal_detector.sv
// Top level of the road signal detector.
// Window vote in the front end; an accepted request is queued, then popped into the output register.
// Throughput: one request per cycle while the queue has space; state update in the back end.
// A 4-entry queue between the two ends absorbs output stalls.
// Synchronous active-low reset restores window, class, signal state and hold registers.
module road_signal_detector
    import rsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // line_count[3:0], distance_mm[35:4]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // signal_state[1:0], line_class[2], state_changed[3]
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [HOLD_W-1:0]     i_cfg_wdata
);

    logic  q_space;
    logic  q_valid;
    logic  push;
    logic  pop;
    t_item push_item;
    t_item head_item;

    rsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .i_line_count  (i_s_axis_tdata[COUNT_W-1:0]),
        .i_distance_mm (i_s_axis_tdata[COUNT_W+DIST_W-1:COUNT_W]),
        .i_space       (q_space),
        .o_ready       (o_s_axis_tready),
        .o_push        (push),
        .o_item        (push_item)
    );

    rsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_space (q_space),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (head_item)
    );

    rsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (head_item),
        .o_pop       (pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata)
    );

endmodule

// File: rtl/rsd_checker.sv
// Port-level checker for the road signal detector, bound to the top level.
module rsd_checker
    import rsd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result dropped or changed while stalled");

    ap_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    ap_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[1:0] != 2'd3)
        else $error("unused signal code");

    ap_chg_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[3] |-> o_m_axis_tdata[1:0] != SIG_NONE)
        else $error("change back to none");

    ap_chg_triple: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[3] |-> o_m_axis_tdata[2] == CLASS_TRIPLE)
        else $error("state change without triple class");

endmodule

bind road_signal_detector rsd_checker u_rsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
